// File: hw/rtl/salcp_pkg.sv
// Shared types, codes and constants of the suffix array and LCP engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package salcp_pkg;

    // Default sizing of the stores.
    localparam int MAX_LEN_DEF = 1024;
    localparam int LEVELS_DEF  = 11;
    localparam int ALPHA       = 256;

    // Fixed payload widths.
    localparam int MODE_W = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 11;
    localparam int STAT_W = 2;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LCP  = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNBUILT = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    // Datapath operation for the current cycle.
    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_F1, OP_F2, OP_F3, OP_F4, OP_HIST, OP_SCAT,
        OP_P1, OP_P2, OP_C1, OP_C2, OP_C3, OP_T1, OP_T2, OP_R1, OP_R2,
        OP_LVL, OP_FIN, OP_QRD, OP_QSET, OP_WRD, OP_WCMP, OP_EMIT
    } op_t;

    // Loop index update.
    typedef enum logic [2:0] {
        IDX_HOLD, IDX_ZERO, IDX_TOP, IDX_INC, IDX_DEC
    } idx_op_t;

    // Loop bound selection.
    typedef enum logic [1:0] {
        LIM_N, LIM_ALPHA, LIM_CLS
    } lim_t;

    typedef struct packed {
        logic    accept;
        op_t     op;
        idx_op_t idx;
        lim_t    lim;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] in_mode;
        logic              in_last;
        logic              in_full;
        logic              in_err;
        logic              lvl0;
        logic              dbl_go;
        logic              at_lim;
        logic              i_zero;
        logic              k_zero;
        logic              out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/salcp_ifs.sv
// Valid/ready channel interfaces for requests and results of the engine.
// Depends on salcp_pkg for the payload widths.
`default_nettype none

interface salcp_req_if import salcp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;

    modport source (output valid, mode, char_code, last, first_index, second_index,
                    input ready);
    modport sink (input valid, mode, char_code, last, first_index, second_index,
                  output ready);
endinterface

interface salcp_rsp_if import salcp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;

    modport source (output valid, value, status, input ready);
    modport sink (input valid, value, status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/salcp_ctrl.sv
// Sequencer of the engine: loads, the prefix-doubling build and queries.
// Depends on salcp_pkg; drives salcp_dp through cmd_t and reads sts_t.
`default_nettype none

module salcp_ctrl import salcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [23:0] {
        S_IDLE  = 24'h000001,
        S_EMIT  = 24'h000002,
        S_Q_RD  = 24'h000004,
        S_Q_SET = 24'h000008,
        S_W_RD  = 24'h000010,
        S_W_CMP = 24'h000020,
        S_B_CLR = 24'h000040,
        S_B_F1  = 24'h000080,
        S_B_F2  = 24'h000100,
        S_B_F3  = 24'h000200,
        S_B_F4  = 24'h000400,
        S_B_F5  = 24'h000800,
        S_B_P1  = 24'h001000,
        S_B_P2  = 24'h002000,
        S_B_C1  = 24'h004000,
        S_B_C2  = 24'h008000,
        S_B_C3  = 24'h010000,
        S_B_LVL = 24'h020000,
        S_B_CHK = 24'h040000,
        S_B_T1  = 24'h080000,
        S_B_T2  = 24'h100000,
        S_B_R1  = 24'h200000,
        S_B_R2  = 24'h400000,
        S_B_FIN = 24'h800000
    } state_t;

    state_t state_reg, state_next;
    logic   hist_reg, hist_next;
    logic   desc;
    logic   f_done;

    assign in_ready = (state_reg == S_IDLE);

    // The scatter of a doubling level walks the elements from the top down.
    assign desc   = !hist_reg && !sts.lvl0;
    assign f_done = desc ? sts.i_zero : sts.at_lim;

    always_comb
    begin
        state_next = state_reg;
        hist_next  = hist_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.in_mode == MODE_LOAD)
                    begin
                        if (sts.in_last)
                        begin
                            cmd.idx    = IDX_ZERO;
                            hist_next  = 1'b1;
                            state_next = S_B_CLR;
                        end
                        else if (sts.in_full)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else if (sts.in_err)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (sts.in_mode == MODE_LCP)
                    begin
                        state_next = S_W_RD;
                    end
                    else
                    begin
                        state_next = S_Q_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_Q_RD:
            begin
                cmd.op     = OP_QRD;
                state_next = S_Q_SET;
            end
            S_Q_SET:
            begin
                cmd.op     = OP_QSET;
                state_next = S_EMIT;
            end
            S_W_RD:
            begin
                cmd.op     = OP_WRD;
                state_next = S_W_CMP;
            end
            S_W_CMP:
            begin
                cmd.op     = OP_WCMP;
                state_next = sts.k_zero ? S_EMIT : S_W_RD;
            end
            S_B_CLR:
            begin
                cmd.op  = OP_CLR;
                cmd.lim = sts.lvl0 ? LIM_ALPHA : LIM_CLS;
                if (sts.at_lim)
                begin
                    cmd.idx    = IDX_ZERO;
                    hist_next  = 1'b1;
                    state_next = S_B_F1;
                end
                else
                begin
                    cmd.idx = IDX_INC;
                end
            end
            S_B_F1:
            begin
                cmd.op     = OP_F1;
                state_next = S_B_F2;
            end
            S_B_F2:
            begin
                cmd.op     = OP_F2;
                state_next = S_B_F3;
            end
            S_B_F3:
            begin
                cmd.op     = OP_F3;
                state_next = S_B_F4;
            end
            S_B_F4:
            begin
                cmd.op     = OP_F4;
                state_next = S_B_F5;
            end
            S_B_F5:
            begin
                cmd.op  = hist_reg ? OP_HIST : OP_SCAT;
                cmd.lim = LIM_N;
                if (f_done)
                begin
                    cmd.idx    = IDX_ZERO;
                    state_next = hist_reg ? S_B_P1 : S_B_C1;
                end
                else
                begin
                    cmd.idx    = desc ? IDX_DEC : IDX_INC;
                    state_next = S_B_F1;
                end
            end
            S_B_P1:
            begin
                cmd.op     = OP_P1;
                state_next = S_B_P2;
            end
            S_B_P2:
            begin
                cmd.op  = OP_P2;
                cmd.lim = sts.lvl0 ? LIM_ALPHA : LIM_CLS;
                if (sts.at_lim)
                begin
                    hist_next  = 1'b0;
                    cmd.idx    = sts.lvl0 ? IDX_ZERO : IDX_TOP;
                    state_next = S_B_F1;
                end
                else
                begin
                    cmd.idx    = IDX_INC;
                    state_next = S_B_P1;
                end
            end
            S_B_C1:
            begin
                cmd.op     = OP_C1;
                state_next = S_B_C2;
            end
            S_B_C2:
            begin
                cmd.op     = OP_C2;
                state_next = S_B_C3;
            end
            S_B_C3:
            begin
                cmd.op  = OP_C3;
                cmd.lim = LIM_N;
                if (sts.at_lim)
                begin
                    state_next = S_B_LVL;
                end
                else
                begin
                    cmd.idx    = IDX_INC;
                    state_next = S_B_C1;
                end
            end
            S_B_LVL:
            begin
                cmd.op     = OP_LVL;
                state_next = S_B_CHK;
            end
            S_B_CHK:
            begin
                cmd.idx    = IDX_ZERO;
                state_next = sts.dbl_go ? S_B_T1 : S_B_R1;
            end
            S_B_T1:
            begin
                cmd.op     = OP_T1;
                state_next = S_B_T2;
            end
            S_B_T2:
            begin
                cmd.op  = OP_T2;
                cmd.lim = LIM_N;
                if (sts.at_lim)
                begin
                    cmd.idx    = IDX_ZERO;
                    hist_next  = 1'b1;
                    state_next = S_B_CLR;
                end
                else
                begin
                    cmd.idx    = IDX_INC;
                    state_next = S_B_T1;
                end
            end
            S_B_R1:
            begin
                cmd.op     = OP_R1;
                state_next = S_B_R2;
            end
            S_B_R2:
            begin
                cmd.op  = OP_R2;
                cmd.lim = LIM_N;
                if (sts.at_lim)
                begin
                    state_next = S_B_FIN;
                end
                else
                begin
                    cmd.idx    = IDX_INC;
                    state_next = S_B_R1;
                end
            end
            S_B_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hist_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hist_reg  <= hist_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/salcp_dp.sv
// Datapath of the engine: string, order, rank, class and count memories,
// loop counters and the result register. Depends on salcp_pkg.
`default_nettype none

module salcp_dp import salcp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int LEVELS  = LEVELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [MODE_W-1:0] mode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              last,
    input  logic [IDX_W-1:0]  first_index,
    input  logic [IDX_W-1:0]  second_index,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [VAL_W-1:0]  value,
    output logic [STAT_W-1:0] status
);

    localparam int AW        = $clog2(MAX_LEN);
    localparam int CW        = $clog2(MAX_LEN + 1);
    localparam int CNT_DEPTH = (MAX_LEN > ALPHA) ? MAX_LEN : ALPHA;
    localparam int KW        = $clog2(CNT_DEPTH);
    localparam int LW        = $clog2(LEVELS);

    // Memories.
    logic [CHAR_W-1:0] text_mem [MAX_LEN];
    logic [AW-1:0]     sa_mem   [MAX_LEN];
    logic [AW-1:0]     rank_mem [MAX_LEN];
    logic [AW-1:0]     shf_mem  [MAX_LEN];
    logic [CW-1:0]     cnt_mem  [CNT_DEPTH];
    logic [AW-1:0]     cls_mem  [LEVELS][MAX_LEN];

    logic [CHAR_W-1:0] text_rd;
    logic [AW-1:0]     sa_rd, rank_rd, shf_rd, cls_rd0, cls_rd1;
    logic [CW-1:0]     cnt_rd;

    logic [AW-1:0] text_ra, text_wa, sa_ra, sa_wa, rank_wa, shf_wa;
    logic [AW-1:0] cls_ra0, cls_ra1, cls_wa;
    logic [LW-1:0] cls_rl0, cls_rl1, cls_wl;
    logic [KW-1:0] cnt_ra, cnt_wa;
    logic [CW-1:0] cnt_wd;
    logic [AW-1:0] sa_wd, rank_wd, shf_wd, cls_wd;
    logic          text_we, sa_we, rank_we, shf_we, cnt_we, cls_we;

    // Control registers.
    logic [CW-1:0] n_reg;
    logic          built_reg;
    logic          out_valid_reg;

    // Working registers.
    logic [KW-1:0]     i_reg;
    logic [CW-1:0]     sum_reg;
    logic [LW-1:0]     h_reg;
    logic              lvl0_reg;
    logic [CW-1:0]     classes_reg, classes_next;
    logic [KW-1:0]     key_reg;
    logic [AW-1:0]     e_reg;
    logic [KW-1:0]     pk0_reg;
    logic [AW-1:0]     pk1_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [AW-1:0]     a_reg, b_reg;
    logic [LW-1:0]     k_reg;
    logic [CW:0]       ans_reg, ans_next;
    logic [VAL_W-1:0]  res_value_reg, out_value_reg;
    logic [STAT_W-1:0] res_status_reg, out_status_reg;

    logic [CW-1:0]   sh, step, n_load, cnt_dec;
    logic [AW-1:0]   shift_pos, pair_pos, a_step, b_step;
    logic [KW-1:0]   cur0;
    logic [AW-1:0]   cur1;
    logic            is_new, load_fits, x_bad, y_bad, cls_eq;
    logic [LW-1:0]   top_c;
    logic [KW:0]     lim_v;

    function automatic logic [AW-1:0] wrap_pos(input logic [CW:0] s, input logic [CW-1:0] len);
        logic [CW:0] lx;
        lx = {1'b0, len};
        wrap_pos = (s >= lx) ? AW'(s - lx) : AW'(s);
    endfunction

    assign sh        = CW'(1) << h_reg;
    assign step      = CW'(1) << k_reg;
    assign shift_pos = wrap_pos((CW+1)'(sa_rd) + (CW+1)'(n_reg - sh), n_reg);
    assign pair_pos  = wrap_pos((CW+1)'(sa_rd) + (CW+1)'(sh), n_reg);
    assign a_step    = wrap_pos((CW+1)'(a_reg) + (CW+1)'(step), n_reg);
    assign b_step    = wrap_pos((CW+1)'(b_reg) + (CW+1)'(step), n_reg);
    assign cnt_dec   = cnt_rd - 1'b1;
    assign cls_eq    = (cls_rd0 == cls_rd1);
    assign ans_next  = ans_reg + (cls_eq ? (CW+1)'(step) : '0);

    // Highest class level that the walk may use for the current length.
    always_comb
    begin
        top_c = '0;
        for (int k = 1; k < LEVELS; k++)
        begin
            if ((64'd1 << k) <= 64'(n_reg))
                top_c = LW'(k);
        end
    end

    // Class pair of the current sorted element against the previous one.
    assign cur0         = lvl0_reg ? KW'(text_rd) : KW'(cls_rd0);
    assign cur1         = lvl0_reg ? '0 : cls_rd1;
    assign is_new       = (i_reg != '0) && ((cur0 != pk0_reg) || (cur1 != pk1_reg));
    assign classes_next = (i_reg == '0) ? CW'(1) : classes_reg + CW'(is_new);

    // Load bookkeeping.
    assign load_fits = built_reg || (n_reg < CW'(MAX_LEN));
    assign n_load    = built_reg ? CW'(1) : (load_fits ? n_reg + 1'b1 : n_reg);
    assign x_bad     = (first_index >= n_reg);
    assign y_bad     = (second_index >= n_reg);

    always_comb
    begin
        case (cmd.lim)
            LIM_ALPHA: lim_v = (KW+1)'(ALPHA);
            LIM_CLS:   lim_v = (KW+1)'(classes_reg);
            default:   lim_v = (KW+1)'(n_reg);
        endcase
    end

    assign sts.in_mode  = mode;
    assign sts.in_last  = last;
    assign sts.in_full  = !load_fits;
    assign sts.in_err   = !built_reg || x_bad || ((mode == MODE_LCP) && y_bad);
    assign sts.lvl0     = lvl0_reg;
    assign sts.dbl_go   = (int'(h_reg) + 1 < LEVELS) && ((64'd1 << h_reg) < 64'(n_reg));
    assign sts.at_lim   = (({1'b0, i_reg} + 1'b1) == lim_v);
    assign sts.i_zero   = (i_reg == '0);
    assign sts.k_zero   = (k_reg == '0);
    assign sts.out_free = !out_valid_reg || rsp_ready;

    // Memory addressing per operation.
    always_comb
    begin
        text_ra = i_reg[AW-1:0];
        sa_ra   = i_reg[AW-1:0];
        cnt_ra  = i_reg;
        cls_rl0 = h_reg;
        cls_ra0 = sa_rd;
        cls_rl1 = h_reg;
        cls_ra1 = pair_pos;
        case (cmd.op)
            OP_C2:  text_ra = sa_rd;
            default: ;
        endcase
        case (cmd.op)
            OP_QRD: sa_ra = a_reg;
            default: ;
        endcase
        case (cmd.op)
            OP_F4:  cnt_ra = key_reg;
            default: ;
        endcase
        case (cmd.op)
            OP_F2:
            begin
                cls_ra0 = shf_rd;
            end
            OP_WRD:
            begin
                cls_rl0 = k_reg;
                cls_ra0 = a_reg;
                cls_rl1 = k_reg;
                cls_ra1 = b_reg;
            end
            default: ;
        endcase
    end

    assign text_we = cmd.accept && (mode == MODE_LOAD) && load_fits;
    assign text_wa = built_reg ? '0 : n_reg[AW-1:0];

    assign sa_we   = (cmd.op == OP_SCAT);
    assign sa_wa   = cnt_dec[AW-1:0];
    assign sa_wd   = e_reg;

    assign rank_we = (cmd.op == OP_R2);
    assign rank_wa = sa_rd;
    assign rank_wd = i_reg[AW-1:0];

    assign shf_we  = (cmd.op == OP_T2);
    assign shf_wa  = i_reg[AW-1:0];
    assign shf_wd  = shift_pos;

    assign cls_we  = (cmd.op == OP_C3);
    assign cls_wl  = lvl0_reg ? '0 : h_reg + 1'b1;
    assign cls_wa  = e_reg;
    assign cls_wd  = AW'(classes_next - 1'b1);

    always_comb
    begin
        cnt_we = 1'b0;
        cnt_wa = i_reg;
        cnt_wd = '0;
        case (cmd.op)
            OP_CLR:
            begin
                cnt_we = 1'b1;
            end
            OP_HIST:
            begin
                cnt_we = 1'b1;
                cnt_wa = key_reg;
                cnt_wd = cnt_rd + 1'b1;
            end
            OP_SCAT:
            begin
                cnt_we = 1'b1;
                cnt_wa = key_reg;
                cnt_wd = cnt_dec;
            end
            OP_P2:
            begin
                cnt_we = 1'b1;
                cnt_wd = sum_reg + cnt_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (text_we)
            text_mem[text_wa] <= char_code;
        text_rd <= text_mem[text_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sa_we)
            sa_mem[sa_wa] <= sa_wd;
        sa_rd <= sa_mem[sa_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
            rank_mem[rank_wa] <= rank_wd;
        rank_rd <= rank_mem[a_reg];
    end

    always_ff @(posedge clk)
    begin
        if (shf_we)
            shf_mem[shf_wa] <= shf_wd;
        shf_rd <= shf_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_wa] <= cnt_wd;
        cnt_rd <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cls_we)
            cls_mem[cls_wl][cls_wa] <= cls_wd;
        cls_rd0 <= cls_mem[cls_rl0][cls_ra0];
        cls_rd1 <= cls_mem[cls_rl1][cls_ra1];
    end

    // Length, build flag and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && (mode == MODE_LOAD))
            begin
                n_reg     <= n_load;
                built_reg <= 1'b0;
            end
            else if (cmd.op == OP_FIN)
            begin
                built_reg <= 1'b1;
            end
            if (cmd.op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        case (cmd.idx)
            IDX_ZERO:
            begin
                i_reg <= '0;
                if (cmd.op != OP_P2)
                    sum_reg <= '0;
            end
            IDX_TOP: i_reg <= KW'(n_reg - 1'b1);
            IDX_INC: i_reg <= i_reg + 1'b1;
            IDX_DEC: i_reg <= i_reg - 1'b1;
            default: ;
        endcase

        if (cmd.accept)
        begin
            mode_reg <= mode;
            a_reg    <= AW'(first_index);
            b_reg    <= AW'(second_index);
            k_reg    <= top_c;
            ans_reg  <= '0;
            lvl0_reg <= 1'b1;
            h_reg    <= '0;
            if (mode == MODE_LOAD)
            begin
                res_value_reg  <= VAL_W'(n_load);
                res_status_reg <= load_fits ? ST_OK : ST_FULL;
            end
            else
            begin
                res_value_reg  <= '0;
                res_status_reg <= !built_reg ? ST_UNBUILT : (sts.in_err ? ST_RANGE : ST_OK);
            end
        end

        case (cmd.op)
            OP_F2:
            begin
                e_reg   <= lvl0_reg ? i_reg[AW-1:0] : shf_rd;
                key_reg <= KW'(text_rd);
            end
            OP_F3:
            begin
                if (!lvl0_reg)
                    key_reg <= KW'(cls_rd0);
            end
            OP_P2:
            begin
                sum_reg <= sum_reg + cnt_rd;
            end
            OP_C2:
            begin
                e_reg <= sa_rd;
            end
            OP_C3:
            begin
                pk0_reg     <= cur0;
                pk1_reg     <= cur1;
                classes_reg <= classes_next;
            end
            OP_LVL:
            begin
                lvl0_reg <= 1'b0;
                if (!lvl0_reg)
                    h_reg <= h_reg + 1'b1;
            end
            OP_QSET:
            begin
                res_value_reg <= VAL_W'((mode_reg == MODE_POS) ? sa_rd : rank_rd);
            end
            OP_WCMP:
            begin
                ans_reg <= ans_next;
                if (cls_eq)
                begin
                    a_reg <= a_step;
                    b_reg <= b_step;
                end
                if (k_reg == '0)
                    res_value_reg <= VAL_W'((ans_next > (CW+1)'(n_reg)) ?
                                            (CW+1)'(n_reg) : ans_next);
                else
                    k_reg <= k_reg - 1'b1;
            end
            OP_EMIT:
            begin
                out_value_reg  <= res_value_reg;
                out_status_reg <= res_status_reg;
            end
            default: ;
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign status    = out_status_reg;

endmodule

`default_nettype wire

// File: hw/rtl/suffix_array_lcp_engine.sv
// Top level of the suffix array and LCP engine.
// Depends on salcp_pkg, salcp_ifs, salcp_ctrl and salcp_dp.
//
// Usage. Requests arrive on the req channel and answers leave on rsp; a
// transfer happens at a rising edge where valid and ready are both high.
// A load request (mode 0) stores one character, so a string streams in
// at one character per cycle while the store has room. A load transfer
// yields no answer unless it carries last or arrives with the store
// already full; a full store drops the character and answers with status 3.
// The load marked last starts the build: counting-sort passes over the
// string, one prefix-doubling level at a time; its answer is the length.
// Position and rank queries pass a read state and a set state before the
// answer is registered for output; the LCP query alternates a read and a
// compare state for each class level from the top level in use for the
// length down to level 0, one class-memory read per level. Reset clears the
// length and the built flag; the memories are left as they are and are only
// read where written. A stalled receiver holds the answer in the output
// register; the next request is still taken, and its answer waits until the
// register frees up.
`default_nettype none

module suffix_array_lcp_engine import salcp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int LEVELS  = LEVELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    salcp_req_if.sink   req,
    salcp_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;

    // The controller sequences the passes; it takes the request valid directly and the rest through the status.
    salcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath owns all storage and the output register.
    salcp_dp #(
        .MAX_LEN (MAX_LEN),
        .LEVELS  (LEVELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (req.mode),
        .char_code    (req.char_code),
        .last         (req.last),
        .first_index  (req.first_index),
        .second_index (req.second_index),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .value        (rsp.value),
        .status       (rsp.status)
    );

endmodule

`default_nettype wire

// File: hw/rtl/salcp_checker.sv
// Port-level checks of the engine and the bind that attaches them.
// Depends on salcp_pkg and on the ports of suffix_array_lcp_engine.
`default_nettype none

module salcp_checker import salcp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic [MODE_W-1:0] req_mode,
    input logic              req_last,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [VAL_W-1:0]  rsp_value,
    input logic [STAT_W-1:0] rsp_status
);

    // An answer held back by the receiver stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("answer withdrawn while stalled");

    // A stalled answer keeps its contents.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_status))
        else $error("answer changed while stalled");

    // Error answers carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_RANGE || rsp_status == ST_UNBUILT)
        |-> rsp_value == '0)
        else $error("error answer with nonzero value");

    // Queries and final loads leave the engine not ready in the cycle after they are taken.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_mode != MODE_LOAD || req_last) |=> !req_ready)
        else $error("engine ready right after a query or build start");

endmodule

bind suffix_array_lcp_engine salcp_checker u_salcp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_mode   (req.mode),
    .req_last   (req.last),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_value  (rsp.value),
    .rsp_status (rsp.status)
);

`default_nettype wire
